[sv/smf_pkg.sv]
// Shared types and constants for the sliding window median filter.
// No dependencies; compile first.
package smf_pkg;

  localparam int unsigned WindowMaxDefault = 16;
  localparam int unsigned LenResetValue    = 16;
  localparam int unsigned SampleW          = 32;
  localparam int unsigned LenW             = 5;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
  } smf_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] filtered;
    logic                      window_full;
  } smf_out_t;

  // per-cycle controls broadcast to every cell
  typedef struct packed {
    logic adv;
    logic clr;
    logic full;
  } smf_ctl_t;

  // ripple signals passed from a cell to its right neighbour
  typedef struct packed {
    logic old;
    logic rem;
    logic le;
  } smf_link_t;

endpackage

[sv/smf_stream_if.sv]
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from smf_pkg at instantiation.
interface smf_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

[sv/sliding_window_median_filter.sv]
// Running median filter over a window of up to WINDOW_MAX signed 32-bit samples.
// Depends on smf_pkg, smf_stream_if and smf_cell.
//
// in_if carries one sample per word, out_if one result word (filtered,
// window_full). cfg_we_i/cfg_wdata_i write the window length (0 reads as 1,
// values above WINDOW_MAX saturate); a write restarts the fill phase.
// While the window fills, each sample is passed through with window_full low;
// afterwards the result is the upper median of the last window_len samples.
// The window is kept sorted in a chain of WINDOW_MAX cells: each accepted
// sample removes the oldest entry once the window is full and is inserted in place.
// The result is registered and valid the cycle after input acceptance; the filter
// takes one word per cycle while out_if.ready is high, as the output register then
// frees; a stalled receiver holds its result and stalls input in the same cycle.
// Reset empties the window, sets the length to 16 (or WINDOW_MAX if smaller)
// and clears the output valid; no clearing pass is needed.
module sliding_window_median_filter #(
  parameter int unsigned WINDOW_MAX = smf_pkg::WindowMaxDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  smf_stream_if.sink               in_if,
  smf_stream_if.source             out_if,
  input  logic                     cfg_we_i,
  input  logic [smf_pkg::LenW-1:0] cfg_wdata_i
);
  import smf_pkg::*;

  localparam int unsigned AgeW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CntW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LenReset = (LenResetValue > WINDOW_MAX) ? WINDOW_MAX
                                                                  : LenResetValue;

  logic [CntW-1:0] len_q, len_d, cnt_q, cnt_d;
  logic            full, in_acc, out_vld_q;
  smf_out_t        out_q;
  smf_ctl_t        ctl;
  logic [AgeW-1:0] age_max, half;
  int unsigned     len_raw;
  smf_in_t         in_word;

  logic                      st_vld [WINDOW_MAX];
  logic signed [SampleW-1:0] st_val [WINDOW_MAX];
  logic [AgeW-1:0]           st_age [WINDOW_MAX];
  logic                      sh_vld [WINDOW_MAX];
  logic signed [SampleW-1:0] sh_val [WINDOW_MAX];
  logic [AgeW-1:0]           sh_age [WINDOW_MAX];
  smf_link_t                 link   [WINDOW_MAX];
  logic signed [SampleW-1:0] nxt_val[WINDOW_MAX];
  logic [WINDOW_MAX-1:0]     old_vec, vld_vec;

  assign in_word     = in_if.word;
  assign in_if.ready = !out_vld_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;
  assign full        = (cnt_q == len_q);
  assign age_max     = AgeW'(len_q - 1'b1);
  assign half        = AgeW'(len_q >> 1);

  assign ctl = '{adv: in_acc && !cfg_we_i, clr: cfg_we_i, full: full};

  always_comb begin
    len_raw = 32'(cfg_wdata_i);
    if (len_raw == 0) begin
      len_raw = 1;
    end else if (len_raw > WINDOW_MAX) begin
      len_raw = WINDOW_MAX;
    end
    len_d = CntW'(len_raw);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      cnt_d = '0;
    end else if (in_acc && !full) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                      l_vld, r_vld;
    logic signed [SampleW-1:0] l_val, r_val;
    logic [AgeW-1:0]           l_age, r_age;
    smf_link_t                 l_link;

    if (i == 0) begin : g_first
      assign l_vld  = 1'b0;
      assign l_val  = '0;
      assign l_age  = '0;
      assign l_link = '{old: 1'b0, rem: 1'b0, le: 1'b1};
    end else begin : g_mid
      assign l_vld  = sh_vld[i-1];
      assign l_val  = sh_val[i-1];
      assign l_age  = sh_age[i-1];
      assign l_link = link[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign r_vld = 1'b0;
      assign r_val = '0;
      assign r_age = '0;
    end else begin : g_inner
      assign r_vld = st_vld[i+1];
      assign r_val = st_val[i+1];
      assign r_age = st_age[i+1];
    end

    smf_cell #(
      .AgeW(AgeW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .age_max_i  (age_max),
      .x_i        (in_word.sample),
      .lft_vld_i  (l_vld),
      .lft_val_i  (l_val),
      .lft_age_i  (l_age),
      .lft_link_i (l_link),
      .rgt_vld_i  (r_vld),
      .rgt_val_i  (r_val),
      .rgt_age_i  (r_age),
      .vld_o      (st_vld[i]),
      .val_o      (st_val[i]),
      .age_o      (st_age[i]),
      .sh_vld_o   (sh_vld[i]),
      .sh_val_o   (sh_val[i]),
      .sh_age_o   (sh_age[i]),
      .link_o     (link[i]),
      .nxt_val_o  (nxt_val[i])
    );

    assign old_vec[i] = link[i].old;
    assign vld_vec[i] = st_vld[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= CntW'(LenReset);
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= len_d;
      end
      cnt_q <= cnt_d;
      if (in_acc) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.filtered    <= full ? nxt_val[half] : in_word.sample;
      out_q.window_full <= full;
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.word  = out_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= len_q)
    else $error("fill count exceeds window length");

  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == cnt_q)
    else $error("occupied cells disagree with fill count");

  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full && !cfg_we_i) |-> $onehot(old_vec))
    else $error("full window without exactly one oldest entry");

  a_no_evict_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full) |-> (old_vec == '0))
    else $error("entry evicted during fill");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (cnt_q == '0) && (vld_vec == '0))
    else $error("length write did not restart fill");

endmodule

[sv/smf_cell.sv]
// One cell of the sorted window chain: holds a sample and its age.
// Depends on smf_pkg.
module smf_cell #(
  parameter int unsigned AgeW = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smf_pkg::smf_ctl_t                 ctl_i,
  input  logic [AgeW-1:0]                   age_max_i,
  input  logic signed [smf_pkg::SampleW-1:0] x_i,
  input  logic                              lft_vld_i,
  input  logic signed [smf_pkg::SampleW-1:0] lft_val_i,
  input  logic [AgeW-1:0]                   lft_age_i,
  input  smf_pkg::smf_link_t                lft_link_i,
  input  logic                              rgt_vld_i,
  input  logic signed [smf_pkg::SampleW-1:0] rgt_val_i,
  input  logic [AgeW-1:0]                   rgt_age_i,
  output logic                              vld_o,
  output logic signed [smf_pkg::SampleW-1:0] val_o,
  output logic [AgeW-1:0]                   age_o,
  output logic                              sh_vld_o,
  output logic signed [smf_pkg::SampleW-1:0] sh_val_o,
  output logic [AgeW-1:0]                   sh_age_o,
  output smf_pkg::smf_link_t                link_o,
  output logic signed [smf_pkg::SampleW-1:0] nxt_val_o
);
  import smf_pkg::*;

  logic                      vld_q, vld_d;
  logic signed [SampleW-1:0] val_q, val_d;
  logic [AgeW-1:0]           age_q, age_d;
  logic                      old, rem, le;

  assign old = ctl_i.full & vld_q & (age_q == age_max_i);
  assign rem = lft_link_i.rem | old;

  // drop the oldest entry by pulling from the right
  assign sh_vld_o = rem ? rgt_vld_i : vld_q;
  assign sh_val_o = rem ? rgt_val_i : val_q;
  assign sh_age_o = rem ? rgt_age_i : age_q;

  assign le = sh_vld_o & (sh_val_o <= x_i);

  always_comb begin
    if (le) begin
      vld_d = 1'b1;
      val_d = sh_val_o;
      age_d = sh_age_o + 1'b1;
    end else if (lft_link_i.le) begin
      vld_d = 1'b1;
      val_d = x_i;
      age_d = '0;
    end else begin
      vld_d = lft_vld_i;
      val_d = lft_val_i;
      age_d = lft_age_i + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clr) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign vld_o     = vld_q;
  assign val_o     = val_q;
  assign age_o     = age_q;
  assign link_o    = '{old: old, rem: rem, le: le};
  assign nxt_val_o = val_d;

endmodule

[test/tb_sliding_window_median_filter.sv]
// Testbench for sliding_window_median_filter: directed and random samples over many window
// lengths, each result checked against a table row or an in-bench running-median model.
// Depends on smf_pkg, smf_stream_if and the filter RTL.
`timescale 1ns / 100ps

module tb_sliding_window_median_filter;
  import smf_pkg::*;

  localparam int NumRandom  = 1450;
  localparam int HoldCycles = 60;
  localparam int IdleLimit  = 3000;
  localparam int NumRows    = 29;

  typedef enum logic {ROW_SAMPLE, ROW_LEN} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [SampleW-1:0]  value;
    logic                typed;
    logic [SampleW-1:0]  exp_filtered;
    logic                exp_full;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [LenW-1:0] cfg_wdata_i;

  smf_stream_if #(.word_t(smf_in_t))  in_ch ();
  smf_stream_if #(.word_t(smf_out_t)) res_ch ();

  sliding_window_median_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [SampleW-1:0] window [WindowMaxDefault];
  int   wr_pos;
  logic filling;
  int   win_len;

  smf_out_t results_due [$];
  logic     row_typed;
  smf_out_t row_exp;
  logic     calm;
  logic [LenW-1:0] last_len_code;
  logic [WindowMaxDefault:0] lens_seen;
  int n_in, n_results, n_bad, n_len_writes, holds;

  row_t dir_rows [NumRows] = '{
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},
    '{ROW_SAMPLE, 32'h5555_5555, 1'b1, 32'h5555_5555, 1'b0},
    '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0005, 1'b1, 32'h0000_0005, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFB, 1'b1, 32'hFFFF_FFFB, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0005, 1'b1, 32'h0000_0005, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0064, 1'b1, 32'h0000_0064, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FF9C, 1'b1, 32'hFFFF_FF9C, 1'b0},
    '{ROW_SAMPLE, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b0},
    '{ROW_SAMPLE, 32'hEDCB_A988, 1'b1, 32'hEDCB_A988, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0003, 1'b1, 32'h0000_0003, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0007, 1'b1, 32'h0000_0007, 1'b0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0,         1'b0},
    // zero length behaves as one
    '{ROW_LEN,    32'd0,         1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0000_002A, 1'b1, 32'h0000_002A, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b1, 32'hFFFF_FFF9, 1'b1},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // oversize length saturates
    '{ROW_LEN,    32'd31,        1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0000_0009, 1'b1, 32'h0000_0009, 1'b0},
    '{ROW_LEN,    32'd2,         1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0000_000A, 1'b1, 32'h0000_000A, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0014, 1'b1, 32'h0000_0014, 1'b0},
    '{ROW_SAMPLE, 32'h0000_000F, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0,         1'b0}
  };

  function automatic void load_len(input logic [LenW-1:0] code);
    if (code == 0) win_len = 1;
    else if (code > WindowMaxDefault) win_len = int'(WindowMaxDefault);
    else win_len = int'(code);
    wr_pos  = 0;
    filling = 1'b1;
    lens_seen[win_len] = 1'b1;
  endfunction

  function automatic smf_out_t predict_filter(input logic signed [SampleW-1:0] s);
    smf_out_t r;
    logic signed [SampleW-1:0] keys [WindowMaxDefault];
    logic signed [SampleW-1:0] k;
    int i, j;
    if (filling && wr_pos < win_len) begin
      window[wr_pos] = s;
      if (wr_pos + 1 >= win_len) filling = 1'b0;
      wr_pos++;
      r.filtered    = s;
      r.window_full = 1'b0;
    end else begin
      filling = 1'b0;
      if (wr_pos >= win_len) wr_pos = 0;
      window[wr_pos] = s;
      wr_pos++;
      for (i = 0; i < win_len; i++) keys[i] = window[i];
      for (i = 1; i < win_len; i++) begin
        k = keys[i];
        j = i;
        while (j > 0 && keys[j-1] > k) begin
          keys[j] = keys[j-1];
          j--;
        end
        keys[j] = k;
      end
      r.filtered    = keys[win_len/2];
      r.window_full = 1'b1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [SampleW-1:0] exp_v,
                               input logic [SampleW-1:0] act_v);
    if (n_bad < 10)
      $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)", $realtime, what,
               $signed(exp_v), exp_v, $signed(act_v), act_v);
    n_bad++;
  endtask

  always @(posedge clk_i) begin : monitor
    smf_out_t exp_w, got_w;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got_w = res_ch.word;
        n_results++;
        if (results_due.size() == 0) begin
          flag_mismatch("unexpected result", '0, got_w.filtered);
        end else begin
          exp_w = results_due.pop_front();
          if (got_w.filtered !== exp_w.filtered)
            flag_mismatch("filtered", exp_w.filtered, got_w.filtered);
          if (got_w.window_full !== exp_w.window_full)
            flag_mismatch("window_full", SampleW'(exp_w.window_full),
                          SampleW'(got_w.window_full));
        end
      end
      if (cfg_we_i) load_len(cfg_wdata_i);
      if (in_ch.valid && in_ch.ready) begin
        exp_w = predict_filter(in_ch.word.sample);
        if (row_typed) exp_w = row_exp;
        results_due.push_back(exp_w);
        n_in++;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no word moved for %0d cycles", IdleLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      // hold off so the input backs up
      if ((holds == 0 && n_in >= 400) || (holds == 1 && n_in >= 1100)) begin
        holds++;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic push_sample(input logic [SampleW-1:0] s, input logic typed,
                             input smf_out_t exp_w);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.word.sample <= s;
    row_typed         <= typed;
    row_exp           <= exp_w;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_len(input logic [LenW-1:0] code);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    last_len_code = code;
    n_len_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return LenW'($urandom_range(17, 31));
      4: return last_len_code;
      default: return LenW'($urandom_range(2, 15));
    endcase
  endfunction

  initial begin
    smf_out_t exp_w;
    int sent, span, i;
    in_ch.valid  = 1'b0;
    in_ch.word   = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    row_typed    = 1'b0;
    row_exp      = '0;
    calm         = 1'b0;
    n_in         = 0;
    n_results    = 0;
    n_bad        = 0;
    n_len_writes = 0;
    holds        = 0;
    lens_seen    = '0;
    last_len_code = LenW'(LenResetValue);
    for (i = 0; i < WindowMaxDefault; i++) window[i] = '0;
    load_len(LenW'(LenResetValue));
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_LEN) begin
        write_len(dir_rows[r].value[LenW-1:0]);
      end else begin
        exp_w.filtered    = dir_rows[r].exp_filtered;
        exp_w.window_full = dir_rows[r].exp_full;
        push_sample(dir_rows[r].value, dir_rows[r].typed, exp_w);
      end
    end

    sent = 0;
    while (sent < NumRandom) begin
      write_len(rand_len());
      span = $urandom_range(20, 90);
      for (i = 0; i < span && sent < NumRandom; i++) begin
        calm = (sent >= 600 && sent < 800);
        push_sample(rand_sample(), 1'b0, '0);
        sent++;
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d samples to %0d results across %0d length writes, %0d distinct lengths,",
             n_in, n_results, n_len_writes, $countones(lens_seen));
    $display("with %0d long receiver hold-offs and %0d mismatches.", holds, n_bad);
    if (n_bad == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
sv/smf_pkg.sv
sv/smf_stream_if.sv
sv/smf_cell.sv
sv/sliding_window_median_filter.sv
test/tb_sliding_window_median_filter.sv
